/* src/aabb_elastic_collision_force_core_defines.svh */
// Assertion macros used by the back end of the collision core
`ifndef AABB_ELASTIC_COLLISION_FORCE_CORE_DEFINES_SVH
`define AABB_ELASTIC_COLLISION_FORCE_CORE_DEFINES_SVH
// assert that a condition implies a consequence in the same cycle
`define AECF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
// assert that a condition implies a consequence in the next cycle
`define AECF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

/* src/aecf_pkg.sv */
`default_nettype none
package aecf_pkg;
  localparam int unsigned MaxEntities = 256;
  localparam int unsigned TimeBits    = 32;
  localparam logic [9:0]  InvStepRst  = 10'd60;
  localparam logic [7:0]  MarginRst   = 8'd2;
  localparam logic [0:0]  RegInvStep  = 1'b0;
  localparam logic [0:0]  RegMargin   = 1'b1;
  localparam logic signed [47:0] ForceMax = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] ForceMin = 48'sh8000_0000_0000;

  typedef struct packed {
    logic [7:0]         other_index;
    logic [31:0]        frame_time;
    logic signed [15:0] offset_x;
    logic signed [15:0] offset_y;
    logic [11:0]        self_width;
    logic [11:0]        self_height;
    logic [11:0]        other_width;
    logic [11:0]        other_height;
    logic [15:0]        mass_self;
    logic [15:0]        mass_other;
    logic signed [23:0] rel_vel_x;
    logic signed [23:0] rel_vel_y;
  } req_t;

  typedef struct packed {
    logic signed [47:0] force_x;
    logic signed [47:0] force_y;
    logic               applied_x;
    logic               applied_y;
    logic               overlap;
  } res_t;

  // classified request handed from front to back
  typedef struct packed {
    logic [7:0]         idx;
    logic [31:0]        t;
    logic [15:0]        m1;
    logic [15:0]        m2;
    logic signed [23:0] dvx;
    logic signed [23:0] dvy;
    logic               base;
    logic               hitx;
    logic               hity;
  } cls_t;
endpackage
`default_nettype wire

/* src/aecf_front.sv */
`default_nettype none
// Front: overlap and hit classification, one request per cycle unless the queue holds its output
module aecf_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire aecf_pkg::req_t req_i,
  input  wire logic [7:0]    margin_i,
  input  wire logic          valid_i,
  output logic               ready_o,
  output aecf_pkg::cls_t     cls_o,
  output logic               valid_o,
  input  wire logic          ready_i
);
  import aecf_pkg::*;
  logic signed [17:0] ox, oy, w1, h1, w2, h2, mg;
  cls_t cls_d, cls_q;
  logic vld_q;

  always_comb begin
    ox = 18'(req_i.offset_x);
    oy = 18'(req_i.offset_y);
    w1 = {6'd0, req_i.self_width};
    h1 = {6'd0, req_i.self_height};
    w2 = {6'd0, req_i.other_width};
    h2 = {6'd0, req_i.other_height};
    mg = {10'd0, margin_i};
    cls_d.idx  = req_i.other_index;
    cls_d.t    = req_i.frame_time;
    cls_d.m1   = req_i.mass_self;
    cls_d.m2   = req_i.mass_other;
    cls_d.dvx  = req_i.rel_vel_x;
    cls_d.dvy  = req_i.rel_vel_y;
    cls_d.base = (req_i.mass_self != 0) && (req_i.mass_other != 0) &&
                 (ox + w2 > 0) && (oy + h2 > 0) && (ox < w1) && (oy < h1);
    cls_d.hitx = !((h1 - mg < oy) || (oy + h2 - mg < 0));
    cls_d.hity = !((w1 - mg < ox) || (ox + w2 - mg < 0));
  end

  assign ready_o = !vld_q || ready_i;
  assign cls_o   = cls_q;
  assign valid_o = vld_q;

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ready_o) begin
      vld_q <= valid_i;
    end
  end
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      cls_q <= cls_d;
    end
  end
endmodule
`default_nettype wire

/* src/aecf_fifo.sv */
`default_nettype none
// Two-entry queue between front and back
module aecf_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire aecf_pkg::cls_t d_i,
  input  wire logic          valid_i,
  output logic               ready_o,
  output aecf_pkg::cls_t     d_o,
  output logic               valid_o,
  input  wire logic          ready_i
);
  import aecf_pkg::*;
  cls_t mem_q [2];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;
  logic wr, rd;

  assign ready_o = cnt_q != 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign d_o     = mem_q[rp_q];
  assign wr = valid_i && ready_o;
  assign rd = valid_o && ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (wr) wp_q <= !wp_q;
      if (rd) rp_q <= !rp_q;
      cnt_q <= cnt_q + 2'(wr) - 2'(rd);
    end
  end
  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= d_i;
  end
endmodule
`default_nettype wire

/* src/aecf_back.sv */
`default_nettype none
// Back: time store lookup, force computation with a serial divider
module aecf_back #(
  parameter int unsigned MAX_ENTITIES = aecf_pkg::MaxEntities,
  parameter int unsigned TIME_BITS    = aecf_pkg::TimeBits
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire aecf_pkg::cls_t cls_i,
  input  wire logic          valid_i,
  output logic               ready_o,
  input  wire logic [9:0]    inv_step_i,
  output aecf_pkg::res_t     res_o,
  output logic               valid_o,
  input  wire logic          ready_i
);
  import aecf_pkg::*;
  `include "aabb_elastic_collision_force_core_defines.svh"
  localparam int unsigned IW = (MAX_ENTITIES > 1) ? $clog2(MAX_ENTITIES) : 1;
  localparam int unsigned NB = 66; // numerator bits for 2*m1*m2*|dv|*inv
  localparam int unsigned CW = $clog2(NB + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_CLR, S_RD, S_MUL1, S_MUL2, S_DIV, S_NEXT, S_OUT
  } state_e;

  state_e state_q;
  logic [TIME_BITS-1:0] tx_mem [MAX_ENTITIES];
  logic [TIME_BITS-1:0] ty_mem [MAX_ENTITIES];
  logic [TIME_BITS-1:0] tx_rd_q, ty_rd_q;
  logic [IW-1:0]  clr_q;
  cls_t           c_q;
  logic [IW-1:0]  idx;
  logic [TIME_BITS-1:0] t_ext;
  logic           ax_q, ay_q, axis_q;
  logic [32:0]    prod_q;    // 2*m1*m2
  logic [33:0]    a_q;       // |dv|*inv
  logic [NB-1:0]  num_q, quo_q;
  logic [16:0]    den_q;
  logic [17:0]    rem_q;
  logic [CW-1:0]  cnt_q;
  logic           neg_q;
  logic signed [47:0] fx_q, fy_q, fsat;
  res_t           res_q;
  logic           out_q;
  logic [23:0]    mag;
  logic [17:0]    rsh;

  assign idx   = IW'(c_q.idx);
  assign t_ext = TIME_BITS'(c_q.t);
  assign mag   = axis_q ? (c_q.dvy < 0 ? 24'(-c_q.dvy) : c_q.dvy)
                        : (c_q.dvx < 0 ? 24'(-c_q.dvx) : c_q.dvx);
  assign rsh   = {rem_q[16:0], num_q[NB-1]};

  // saturate the signed quotient
  always_comb begin
    if (neg_q) begin
      fsat = (quo_q > NB'(64'h8000_0000_0000)) ? ForceMin : 48'(-quo_q);
    end else begin
      fsat = (quo_q > NB'(64'h7FFF_FFFF_FFFF)) ? ForceMax : 48'(quo_q);
    end
  end

  assign ready_o = state_q == S_IDLE;
  assign valid_o = out_q;
  assign res_o   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      clr_q   <= '0;
      out_q   <= 1'b0;
    end else begin
      unique case (state_q)
        S_CLR: begin
          if (clr_q == IW'(MAX_ENTITIES - 1)) state_q <= S_IDLE;
          clr_q <= clr_q + 1'b1;
        end
        S_IDLE: if (valid_i) begin
          c_q <= cls_i;
          state_q <= S_RD;
        end
        S_RD: begin
          ax_q <= c_q.base && c_q.hitx && (tx_rd_q < t_ext);
          ay_q <= c_q.base && c_q.hity && (ty_rd_q < t_ext);
          prod_q <= 33'({c_q.m1, 1'b0}) * 33'(c_q.m2);
          den_q  <= 17'(c_q.m1) + 17'(c_q.m2);
          fx_q <= '0; fy_q <= '0;
          axis_q <= 1'b0;
          state_q <= S_MUL1;
        end
        S_MUL1: begin
          if ((axis_q ? ay_q : ax_q) && den_q != 0) begin
            a_q   <= 34'(mag) * 34'(inv_step_i);
            neg_q <= axis_q ? c_q.dvy[23] : c_q.dvx[23];
            state_q <= S_MUL2;
          end else begin
            state_q <= S_NEXT;
          end
        end
        S_MUL2: begin
          num_q <= NB'(prod_q) * NB'(a_q);
          rem_q <= '0; quo_q <= '0; cnt_q <= '0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          // restoring division, one bit a cycle
          if (rsh >= {1'b0, den_q}) begin
            rem_q <= rsh - {1'b0, den_q};
            quo_q <= {quo_q[NB-2:0], 1'b1};
          end else begin
            rem_q <= rsh;
            quo_q <= {quo_q[NB-2:0], 1'b0};
          end
          num_q <= {num_q[NB-2:0], 1'b0};
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CW'(NB - 1)) state_q <= S_NEXT;
        end
        S_NEXT: begin
          if ((axis_q ? ay_q : ax_q) && den_q != 0 && quo_q != '0) begin
            if (axis_q) fy_q <= fsat; else fx_q <= fsat;
          end
          quo_q <= '0; neg_q <= 1'b0;
          if (axis_q) state_q <= S_OUT;
          else begin
            axis_q <= 1'b1;
            state_q <= S_MUL1;
          end
        end
        S_OUT: if (!out_q || ready_i) begin
          res_q.force_x   <= fx_q;
          res_q.force_y   <= fy_q;
          res_q.applied_x <= ax_q;
          res_q.applied_y <= ay_q;
          res_q.overlap   <= c_q.base;
          out_q <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
      if (out_q && ready_i && !(state_q == S_OUT)) out_q <= 1'b0;
    end
  end

  // time stores: clearing pass, read, and update
  always_ff @(posedge clk_i) begin
    if (state_q == S_CLR) begin
      tx_mem[clr_q] <= '0;
      ty_mem[clr_q] <= '0;
    end else if (state_q == S_NEXT && !axis_q) begin
      if (ax_q) tx_mem[idx] <= t_ext;
      if (ay_q) ty_mem[idx] <= t_ext;
    end
    tx_rd_q <= tx_mem[IW'(cls_i.idx)];
    ty_rd_q <= ty_mem[IW'(cls_i.idx)];
  end

  `AECF_ASSERT_IMP(a_no_accept_clr, state_q == S_CLR, !ready_o)
  `AECF_ASSERT_NEXT(a_take_rd, ready_o && valid_i, state_q == S_RD)
  `AECF_ASSERT_IMP(a_applied_ov, valid_o && (res_o.applied_x || res_o.applied_y), res_o.overlap)
endmodule
`default_nettype wire

/* src/aabb_elastic_collision_force_core.sv */
`default_nettype none
// Elastic collision force core. The back end takes one pair at a time and takes no
// new pair before the result of the last one is registered; each hit axis adds the
// operand multiply and the one-bit-a-cycle 66-bit division for that axis.
// A result not yet popped holds the back end. The front classifies overlap and
// hits and feeds a two-entry queue. After reset a clearing pass zeros the
// last-hit time stores; no pair is taken during it.
module aabb_elastic_collision_force_core #(
  parameter int unsigned MAX_ENTITIES = aecf_pkg::MaxEntities,
  parameter int unsigned TIME_BITS    = aecf_pkg::TimeBits
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  output logic                full_o,
  input  wire aecf_pkg::req_t req_i,
  output logic                empty_o,
  input  wire logic           pop_i,
  output aecf_pkg::res_t      res_o,
  input  wire logic           cfg_we_i,
  input  wire logic [0:0]     cfg_idx_i,
  input  wire logic [9:0]     cfg_data_i
);
  import aecf_pkg::*;
  logic [9:0] inv_q;
  logic [7:0] mg_q;
  cls_t f_cls, q_cls;
  logic f_vld, f_rdy, q_vld, q_rdy, f_in_rdy, b_vld;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_q <= InvStepRst;
      mg_q  <= MarginRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegInvStep: inv_q <= cfg_data_i;
        RegMargin:  mg_q  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  assign full_o  = !f_in_rdy;
  assign empty_o = !b_vld;

  aecf_front u_front (
    .clk_i, .rst_ni, .req_i, .margin_i(mg_q), .valid_i(push_i),
    .ready_o(f_in_rdy), .cls_o(f_cls), .valid_o(f_vld), .ready_i(f_rdy)
  );
  aecf_fifo u_fifo (
    .clk_i, .rst_ni, .d_i(f_cls), .valid_i(f_vld), .ready_o(f_rdy),
    .d_o(q_cls), .valid_o(q_vld), .ready_i(q_rdy)
  );
  aecf_back #(.MAX_ENTITIES(MAX_ENTITIES), .TIME_BITS(TIME_BITS)) u_back (
    .clk_i, .rst_ni, .cls_i(q_cls), .valid_i(q_vld), .ready_o(q_rdy),
    .inv_step_i(inv_q), .res_o, .valid_o(b_vld), .ready_i(pop_i)
  );
endmodule
`default_nettype wire
